### sv/edd_pkg.sv
// Package for the error diffusion ditherer.
// Register indices, reset values and quantizer constants; no dependencies.
`default_nettype none

package edd_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int LEVELS_W = 9;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_index_t CFG_GREY_LEVELS  = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd768;
    localparam logic [LEVELS_W-1:0] LEVELS_RST = 9'd16;

    // quantizer: q = floor(x / 510), x < 2^17, via reciprocal floor(2^26 / 510)
    localparam int X_W         = 17;
    localparam int QDIV        = 510;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_510 = 18'd131586;

endpackage

`default_nettype wire

### sv/edd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; contents are undefined after reset.
`default_nettype none

module edd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/error_diffusion_dither_core.sv
// Floyd-Steinberg error diffusion ditherer, top level.
// Depends on edd_pkg and edd_ram (next-row error line).
// One pixel at a time: a transaction is taken only in idle and passes through read, three
// quantizer steps, the one-bit-per-cycle divider that forms the output level, error,
// line RAM writes (one more write on the last column) and output, which waits on m_tready.
// Reset (asynchronous, rst_n low) clears counters, carried errors and handshakes; the
// error line RAM is not cleared, row 0 ignores what it reads.
`default_nettype none

module error_diffusion_dither_core #(
    parameter int MAX_WIDTH     = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [edd_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [edd_pkg::PIX_W-1:0]     m_tdata,   // [7:0] pixel_out
    output logic                               m_tlast,   // last_pixel
    input  wire logic                          cfg_we,
    input  wire logic [edd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [edd_pkg::CFG_DATA_W-1:0] cfg_data
);

    import edd_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = ((CW + 1) > (WIDTH_W + 1)) ? (CW + 1) : (WIDTH_W + 1);
    localparam int ERRW = 12 + F;
    localparam int VW   = ERRW + 2;
    localparam int LW   = 8 + F;          // level / working value width
    localparam int QW   = 8 + F;          // quotient width of the level divider
    localparam int DCW  = $clog2(QW + 1);
    localparam int SHW  = ERRW + 4;
    localparam int XSW  = 18 + F;
    localparam int FULL = 255 * (2 ** F);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_QMUL  = 4'd2;
    localparam logic [3:0] S_QREC  = 4'd3;
    localparam logic [3:0] S_QCOR  = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_WR1   = 4'd8;
    localparam logic [3:0] S_WR2   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [LEVELS_W-1:0] levels_reg;

    logic [CW-1:0]       column_count_reg;
    logic [HEIGHT_W-1:0] row_count_reg;

    logic signed [ERRW-1:0] right_reg, diag_reg, pend_reg;

    logic [PIX_W-1:0]  pixel_reg;
    logic [7:0]        l1_reg;
    logic              row_end_reg, img_end_reg;
    logic [LW-1:0]     v_reg;
    logic [X_W-1:0]    x_reg;
    logic [7:0]        qe_reg, q_reg;
    logic [7:0]        rem_reg;
    logic [QW-1:0]     dnum_reg, quot_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic signed [ERRW-1:0] err_reg;

    logic              m_tvalid_reg;
    logic [PIX_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;

    logic              in_fire, out_load;

    // clamped configuration
    logic [CMPW-1:0]     w_eff, col_inc;
    logic [HEIGHT_W:0]   h_eff, row_inc;
    logic [7:0]          l1_next;
    logic                row_end_next, img_end_next;

    // datapath
    logic [ERRW-1:0]        ram_rdata;
    logic signed [ERRW-1:0] line_err;
    logic signed [VW-1:0]   vsum;
    logic [LW-1:0]          v_next;
    logic [LW+7:0]          xprod;
    logic [XSW-1:0]         xsum;
    logic [X_W+RECIP_W-1:0] rprod;
    logic [X_W-1:0]         rcor;
    logic [7:0]             q_next;
    logic [15:0]            m255;
    logic [8:0]             trial;
    logic                   trial_ge;
    logic signed [ERRW-1:0] err_calc;
    logic signed [SHW-1:0]  p7, p5, p3, p1;
    logic signed [ERRW-1:0] s7, s5, s3, s1;

    logic              ram_we;
    logic [CW-1:0]     ram_waddr;
    logic [ERRW-1:0]   ram_wdata;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // configuration clamps
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CMPW'(1);
        else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else
            w_eff = CMPW'(width_reg);

        if (height_reg == '0)
            h_eff = (HEIGHT_W + 1)'(1);
        else
            h_eff = (HEIGHT_W + 1)'(height_reg);

        if (levels_reg < LEVELS_W'(2))
            l1_next = 8'd1;
        else if (levels_reg > LEVELS_W'(256))
            l1_next = 8'd255;
        else
            l1_next = 8'(levels_reg - LEVELS_W'(1));
    end

    assign col_inc      = CMPW'(column_count_reg) + CMPW'(1);
    assign row_inc      = (HEIGHT_W + 1)'(row_count_reg) + (HEIGHT_W + 1)'(1);
    assign row_end_next = (col_inc >= w_eff);
    assign img_end_next = (row_inc >= h_eff);

    // working value: pixel plus left share plus row-above shares, clamped
    assign line_err = (row_count_reg != '0) ? $signed(ram_rdata) : '0;
    assign vsum     = $signed(VW'({pixel_reg, {F{1'b0}}})) + VW'(right_reg) + VW'(line_err);

    always_comb
    begin
        if (vsum < 0)
            v_next = '0;
        else if (vsum > $signed(VW'(FULL)))
            v_next = LW'(FULL);
        else
            v_next = vsum[LW-1:0];
    end

    // quantizer index
    assign xprod  = v_reg * l1_reg;
    assign xsum   = XSW'({xprod, 1'b0}) + XSW'(FULL);
    assign rprod  = x_reg * RECIP_510;
    assign rcor   = x_reg - X_W'(X_W'(qe_reg) * X_W'(QDIV));
    assign q_next = qe_reg + ((rcor >= X_W'(QDIV)) ? 8'd1 : 8'd0);

    // level divider: (q*255 << F) / (levels-1)
    assign m255     = 16'(q_reg) * 16'd255;
    assign trial    = {rem_reg, dnum_reg[QW-1]};
    assign trial_ge = (trial >= {1'b0, l1_reg});

    // error and its weighted shares, floor(err*w/16)
    assign err_calc = $signed(ERRW'(v_reg) - ERRW'(quot_reg));
    assign p7 = err_reg * $signed(SHW'(7));
    assign p5 = err_reg * $signed(SHW'(5));
    assign p3 = err_reg * $signed(SHW'(3));
    assign p1 = err_reg * $signed(SHW'(1));
    assign s7 = $signed(p7[SHW-1:4]);
    assign s5 = $signed(p5[SHW-1:4]);
    assign s3 = $signed(p3[SHW-1:4]);
    assign s1 = $signed(p1[SHW-1:4]);

    // line RAM writes: left neighbour finalised in WR1, current column at row end in WR2
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = column_count_reg;
        ram_wdata = pend_reg;
        case (state_reg)
            S_WR1:
            begin
                ram_we    = (column_count_reg != '0);
                ram_waddr = column_count_reg - CW'(1);
                ram_wdata = pend_reg + s3;
            end
            S_WR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = column_count_reg;
                ram_wdata = pend_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    edd_ram #(
        .WIDTH (ERRW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (column_count_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_READ;
            S_READ:  state_next = S_QMUL;
            S_QMUL:  state_next = S_QREC;
            S_QREC:  state_next = S_QCOR;
            S_QCOR:  state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:   if (dcnt_reg == DCW'(1)) state_next = S_ERR;
            S_ERR:   state_next = S_WR1;
            S_WR1:   state_next = row_end_reg ? S_WR2 : S_OUT;
            S_WR2:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            width_reg        <= WIDTH_RST;
            height_reg       <= HEIGHT_RST;
            levels_reg       <= LEVELS_RST;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            right_reg        <= '0;
            diag_reg         <= '0;
            pend_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                    CFG_GREY_LEVELS:  levels_reg <= cfg_data[LEVELS_W-1:0];
                    default:          ;
                endcase
            end

            if (state_reg == S_WR1)
            begin
                pend_reg  <= diag_reg + s5;
                right_reg <= row_end_reg ? '0 : s7;
                diag_reg  <= row_end_reg ? '0 : s1;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                if (row_end_reg)
                begin
                    column_count_reg <= '0;
                    row_count_reg    <= img_end_reg ? '0 : row_count_reg + HEIGHT_W'(1);
                end
                else
                begin
                    column_count_reg <= column_count_reg + CW'(1);
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pixel_reg   <= s_tdata;
            l1_reg      <= l1_next;
            row_end_reg <= row_end_next;
            img_end_reg <= img_end_next;
        end
        if (state_reg == S_READ)
            v_reg <= v_next;
        if (state_reg == S_QMUL)
            x_reg <= xsum[F +: X_W];
        if (state_reg == S_QREC)
            qe_reg <= rprod[RECIP_SHIFT +: 8];
        if (state_reg == S_QCOR)
            q_reg <= q_next;
        if (state_reg == S_DINIT)
        begin
            rem_reg  <= m255[15:8];
            dnum_reg <= {m255[7:0], {F{1'b0}}};
            dcnt_reg <= DCW'(QW);
        end
        if (state_reg == S_DIV)
        begin
            rem_reg  <= trial_ge ? 8'(trial - {1'b0, l1_reg}) : trial[7:0];
            dnum_reg <= {dnum_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], trial_ge};
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        if (state_reg == S_ERR)
            err_reg <= err_calc;
        if (out_load)
        begin
            m_tdata_reg <= quot_reg[F +: PIX_W];
            m_tlast_reg <= row_end_reg && img_end_reg;
        end
    end

    a_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DINIT) |-> (q_reg <= l1_reg))
        else $error("quantizer index above level count");

    a_rcor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QCOR) |-> (rcor < X_W'(2 * QDIV)))
        else $error("reciprocal estimate off by more than one");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |-> (quot_reg <= QW'(FULL)))
        else $error("level out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW + 1)'(column_count_reg) < (CW + 1)'(MAX_WIDTH)))
        else $error("column counter beyond line buffer");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("second transaction taken while one in flight");

endmodule

`default_nettype wire
